[design/crcfcr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crcfcr_pkg
// Shared types, constants and the CRC-16/MODBUS byte update used by the
// framed command receiver.
// ----------------------------------------------------------------------------
package crcfcr_pkg;

  // Register map: register index = paddr[3:2].
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;
  localparam logic [1:0] REG_HDR_FIRST  = 2'd0;
  localparam logic [1:0] REG_HDR_SECOND = 2'd1;
  localparam logic [1:0] REG_CRC_EN     = 2'd2;

  localparam logic [7:0] RST_HDR_FIRST  = 8'h00;
  localparam logic [7:0] RST_HDR_SECOND = 8'h00;
  localparam logic       RST_CRC_EN     = 1'b1;

  // CRC-16/MODBUS: init FFFF, reflected polynomial A001, no final xor.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Frame overhead beyond the payload length, with and without the trailer.
  localparam logic [8:0] OVH_CRC    = 9'd5;
  localparam logic [8:0] OVH_NO_CRC = 9'd3;

  // Frame layout.
  localparam int unsigned CMD_BYTES   = 5;
  localparam logic [7:0]  IDX_LEN     = 8'd2;
  localparam logic [7:0]  IDX_CMD0    = 8'd3;
  localparam logic [7:0]  MIN_FRAME   = 8'd3;

  // Command characters.
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_P = 8'h50;
  localparam logic [7:0] CH_O = 8'h4F;
  localparam logic [7:0] CH_I = 8'h49;
  localparam logic [7:0] CH_A = 8'h41;

  typedef enum logic [2:0] {
    OP_CFG_PWM  = 3'd0,
    OP_CFG_OUT  = 3'd1,
    OP_CFG_IN   = 3'd2,
    OP_CFG_ADC  = 3'd3,
    OP_SET_PWM  = 3'd4,
    OP_SET_DIG  = 3'd5,
    OP_GET_DIG  = 3'd6,
    OP_GET_ADC  = 3'd7
  } op_kind_t;

  typedef struct packed {
    logic [7:0] hdr_first;
    logic [7:0] hdr_second;
    logic       crc_en;
  } cfg_t;

  typedef logic [CMD_BYTES-1:0][7:0] cmd_bytes_t;

  typedef struct packed {
    logic good;   // this byte closed a frame that passed its check
  } frm_status_t;

  typedef struct packed {
    op_kind_t    op_kind;
    logic [7:0]  pin;
    logic [7:0]  byte_value;
    logic [15:0] word_value;
  } result_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

[design/crcfcr_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crcfcr_cfg
// APB-style register block holding the header bytes and the CRC enable.
// ----------------------------------------------------------------------------
module crcfcr_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [crcfcr_pkg::PADDR_W-1:0] paddr,
  input  wire logic [crcfcr_pkg::PDATA_W-1:0] pwdata,
  output      logic [crcfcr_pkg::PDATA_W-1:0] prdata,
  output      logic                          pready,
  output      crcfcr_pkg::cfg_t              cfg
);

  crcfcr_pkg::cfg_t cfg_r, cfg_nxt;
  logic             wr_en;
  logic [1:0]       reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        crcfcr_pkg::REG_HDR_FIRST:  cfg_nxt.hdr_first  = pwdata[7:0];
        crcfcr_pkg::REG_HDR_SECOND: cfg_nxt.hdr_second = pwdata[7:0];
        crcfcr_pkg::REG_CRC_EN:     cfg_nxt.crc_en     = pwdata[0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hdr_first  <= crcfcr_pkg::RST_HDR_FIRST;
      cfg_r.hdr_second <= crcfcr_pkg::RST_HDR_SECOND;
      cfg_r.crc_en     <= crcfcr_pkg::RST_CRC_EN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      crcfcr_pkg::REG_HDR_FIRST:  prdata = {24'h000000, cfg_r.hdr_first};
      crcfcr_pkg::REG_HDR_SECOND: prdata = {24'h000000, cfg_r.hdr_second};
      crcfcr_pkg::REG_CRC_EN:     prdata = {31'h00000000, cfg_r.crc_en};
      default:                    prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

[design/crcfcr_framer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crcfcr_framer
// Header hunt, byte counting, running CRC and command byte capture. Works
// on one byte per cycle when step is high.
// ----------------------------------------------------------------------------
module crcfcr_framer (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    step,
  input  wire logic [7:0]              rx_byte,
  input  wire crcfcr_pkg::cfg_t        cfg,
  output      crcfcr_pkg::frm_status_t status,
  output      crcfcr_pkg::cmd_bytes_t  cmd
);

  logic [7:0]             cnt_r, cnt_nxt;
  logic [7:0]             len_r, len_nxt;
  logic [15:0]            crc_r, crc_nxt;
  logic [7:0]             rec0_r, rec0_nxt;
  logic [7:0]             rec1_r, rec1_nxt;
  crcfcr_pkg::cmd_bytes_t cmd_r, cmd_nxt;

  logic       hunting;
  logic       proceed;
  logic [7:0] cnt_inc;
  logic [8:0] target;
  logic       hit;

  assign hunting = (cnt_r == 8'd0);
  // The first header byte is only tested while hunting; a wrong second
  // header byte drops back to hunting without testing it again.
  assign proceed = !(hunting && rx_byte != cfg.hdr_first) &&
                   !(cnt_r == 8'd1 && rx_byte != cfg.hdr_second);
  assign cnt_inc = cnt_r + 8'd1;

  always_comb begin
    crc_nxt  = hunting ? crcfcr_pkg::CRC_INIT : crc_r;
    rec0_nxt = hunting ? 8'h00 : rec1_r;
    rec1_nxt = rx_byte;
    if (cnt_r >= crcfcr_pkg::IDX_LEN) begin
      crc_nxt = crcfcr_pkg::crc_feed(crc_r, rec0_r);
    end
    len_nxt = (cnt_r == crcfcr_pkg::IDX_LEN) ? rx_byte : len_r;
    for (int k = 0; k < crcfcr_pkg::CMD_BYTES; k++) begin
      cmd_nxt[k] = (cnt_r == crcfcr_pkg::IDX_CMD0 + 8'(k)) ? rx_byte : cmd_r[k];
    end
  end

  assign target = {1'b0, len_nxt} +
                  (cfg.crc_en ? crcfcr_pkg::OVH_CRC : crcfcr_pkg::OVH_NO_CRC);
  // A count that wraps to zero is below the minimum, so it never hits.
  assign hit = proceed && (cnt_inc >= crcfcr_pkg::MIN_FRAME) &&
               ({1'b0, cnt_inc} == target);

  always_comb begin
    if (!proceed || hit) begin
      cnt_nxt = 8'd0;
    end else begin
      cnt_nxt = cnt_inc;
    end
  end

  assign status.good = hit && (!cfg.crc_en || ({rec0_nxt, rec1_nxt} == crc_nxt));
  assign cmd         = cmd_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 8'd0;
      len_r  <= 8'd0;
      crc_r  <= crcfcr_pkg::CRC_INIT;
      rec0_r <= 8'h00;
      rec1_r <= 8'h00;
      cmd_r  <= '0;
    end else if (step) begin
      cnt_r <= cnt_nxt;
      if (proceed) begin
        len_r  <= len_nxt;
        crc_r  <= crc_nxt;
        rec0_r <= rec0_nxt;
        rec1_r <= rec1_nxt;
        cmd_r  <= cmd_nxt;
      end
    end
  end

  a_hit_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (step && hit) |=> (cnt_r == 8'd0))
    else $error("framer: count not cleared after frame end");

  a_hunt_keeps_crc: assert property (@(posedge clk) disable iff (!rst_n)
    (step && hunting && rx_byte != cfg.hdr_first) |=> ($stable(crc_r) && $stable(rec1_r)))
    else $error("framer: state changed on a non-header byte while hunting");

  a_recent_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (step && proceed) |=> (rec1_r == $past(rx_byte)))
    else $error("framer: newest frame byte not captured");

endmodule
`default_nettype wire

[design/crcfcr_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crcfcr_decoder
// Turns the five command bytes of a frame into one command.
// ----------------------------------------------------------------------------
module crcfcr_decoder (
  input  wire crcfcr_pkg::cmd_bytes_t cmd,
  output      logic                   known,
  output      crcfcr_pkg::result_t    res
);

  always_comb begin
    known          = 1'b1;
    res.op_kind    = crcfcr_pkg::OP_CFG_PWM;
    res.pin        = cmd[1];
    res.byte_value = 8'h00;
    res.word_value = 16'h0000;
    case (cmd[0])
      crcfcr_pkg::CH_C: begin
        res.pin = cmd[2];
        case (cmd[1])
          crcfcr_pkg::CH_P: begin
            res.op_kind    = crcfcr_pkg::OP_CFG_PWM;
            res.word_value = {cmd[3], cmd[4]};
          end
          crcfcr_pkg::CH_O: res.op_kind = crcfcr_pkg::OP_CFG_OUT;
          crcfcr_pkg::CH_I: begin
            res.op_kind    = crcfcr_pkg::OP_CFG_IN;
            res.byte_value = cmd[3];
            res.word_value = {8'h00, cmd[4]};
          end
          crcfcr_pkg::CH_A: begin
            res.op_kind    = crcfcr_pkg::OP_CFG_ADC;
            res.byte_value = cmd[3];
            res.word_value = {8'h00, cmd[4]};
          end
          default: known = 1'b0;
        endcase
      end
      crcfcr_pkg::CH_P: begin
        res.op_kind    = crcfcr_pkg::OP_SET_PWM;
        res.word_value = {cmd[2], cmd[3]};
      end
      crcfcr_pkg::CH_O: begin
        res.op_kind    = crcfcr_pkg::OP_SET_DIG;
        res.byte_value = cmd[2];
      end
      crcfcr_pkg::CH_I: res.op_kind = crcfcr_pkg::OP_GET_DIG;
      crcfcr_pkg::CH_A: res.op_kind = crcfcr_pkg::OP_GET_ADC;
      default:          known = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

[design/crc_framed_command_receiver_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc_framed_command_receiver_core
// Receives framed command bytes, checks the CRC-16/MODBUS trailer if enabled
// and emits one decoded command for every good frame with a known command.
//
//   Channel   Direction  Handshake               Payload
//   in_       input      in_valid / in_stall     in_rx_byte
//   out_      output     out_valid / out_stall   out_op_kind, out_pin,
//                                                out_byte_value, out_word_value
//   config    input      psel/penable/pready     paddr, pwdata, prdata
//
// One byte is taken every cycle unless in_stall is raised. A byte is held
// in the input register; the framer, CRC update and decoder then work on it
// combinationally and load the result register, which drives the command
// outputs. Reset is synchronous and returns the framer to header hunting.
// While a result waits under out_stall, the input register holds its byte
// and in_stall is raised once that register is full.
// ----------------------------------------------------------------------------
module crc_framed_command_receiver_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output      logic                           in_stall,
  input  wire logic [7:0]                     in_rx_byte,
  output      logic                           out_valid,
  input  wire logic                           out_stall,
  output      logic [2:0]                     out_op_kind,
  output      logic [7:0]                     out_pin,
  output      logic [7:0]                     out_byte_value,
  output      logic [15:0]                    out_word_value,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [crcfcr_pkg::PADDR_W-1:0] paddr,
  input  wire logic [crcfcr_pkg::PDATA_W-1:0] pwdata,
  output      logic [crcfcr_pkg::PDATA_W-1:0] prdata,
  output      logic                           pready
);

  crcfcr_pkg::cfg_t        cfg;
  crcfcr_pkg::frm_status_t status;
  crcfcr_pkg::cmd_bytes_t  cmd;
  crcfcr_pkg::result_t     res;
  logic                    known;

  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r;
  logic       out_valid_r, out_valid_nxt;
  crcfcr_pkg::result_t res_r;

  logic in_acc;
  logic out_free;
  logic step;
  logic load;

  crcfcr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  crcfcr_framer u_framer (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (in_byte_r),
    .cfg     (cfg),
    .status  (status),
    .cmd     (cmd)
  );

  crcfcr_decoder u_decoder (
    .cmd   (cmd),
    .known (known),
    .res   (res)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign step     = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign in_acc   = in_valid && !in_stall;
  assign load     = step && status.good && known;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_acc) begin
      in_valid_nxt = 1'b1;
    end else if (step) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_byte_r <= in_rx_byte;
    end
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_op_kind    = res_r.op_kind;
  assign out_pin        = res_r.pin;
  assign out_byte_value = res_r.byte_value;
  assign out_word_value = res_r.word_value;

  a_result_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(step))
    else $error("core: result appeared without a processed item");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_valid_r)
    else $error("core: accepted item not held in the input register");

  a_blocked_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && out_valid_r && out_stall) |=> (in_valid_r && $stable(in_byte_r)))
    else $error("core: waiting item lost while the result is stalled");

endmodule
`default_nettype wire
